### src/rch_pkg.sv
// shared types, widths and constants for the radial cone height block
// no dependencies; imported by every module of the block
package rch_pkg;

   localparam int LOD_W     = 4;
   localparam int MAX_LOD   = 9;
   localparam int LOD_RESET = 9;
   localparam int COORD_W   = 10;
   localparam int SIDE_W    = COORD_W + 1;
   localparam int DIFF_W    = 10;
   localparam int D2_W      = 20;
   localparam int FRAC_BITS = 16;
   localparam int ROOT_W    = (D2_W + 2 * FRAC_BITS + 1) / 2;
   localparam int REM_W     = ROOT_W + 3;
   localparam int HEIGHT_W  = 17;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = 2;
   localparam int Q_CNT_W   = Q_PTR_W + 1;

   typedef struct packed {
      logic [LOD_W-1:0] lod;
      logic             oor;
      logic [D2_W-1:0]  d2;
   } item_type;

   typedef struct packed {
      logic full;
      logic avail;
   } q_stat_type;

   typedef struct packed {
      logic [LOD_W-1:0]  lod;
      logic              oor;
      logic [D2_W-1:0]   d2;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
   } sq_stage_type;

endpackage

### src/rch_front.sv
// front end: takes pixel beats, checks the grid bounds and forms the squared distance
// depends on rch_pkg
module rch_front
   import rch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [LOD_W-1:0]      lod,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_W-1:0]    column,
   input  logic [COORD_W-1:0]    row,
   input  q_stat_type            q_stat,
   output logic                  push,
   output item_type              push_item
);

   logic              valid_ff, valid_in;
   logic [LOD_W-1:0]  lod_ff;
   logic              oor_ff, oor_in;
   logic [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SIDE_W-1:0] side;
   logic [COORD_W-1:0] half;
   logic              take;
   logic [D2_W-1:0]   dx_sq, dy_sq;

   assign push     = valid_ff && !q_stat.full;
   assign in_ready = !valid_ff || push;
   assign take     = in_valid && in_ready;

   always_comb begin
      side   = SIDE_W'(2) << lod;
      half   = COORD_W'(1) << lod;
      oor_in = ({1'b0, column} >= side) || ({1'b0, row} >= side);
      dx_in  = (column >= half) ? DIFF_W'(column - half) : DIFF_W'(half - column);
      dy_in  = (row >= half) ? DIFF_W'(row - half) : DIFF_W'(half - row);
      valid_in = take ? 1'b1 : (push ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         lod_ff <= lod;
         oor_ff <= oor_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
      end
   end

   always_comb begin
      dx_sq = D2_W'(dx_ff) * D2_W'(dx_ff);
      dy_sq = D2_W'(dy_ff) * D2_W'(dy_ff);
      push_item.lod = lod_ff;
      push_item.oor = oor_ff;
      // distance is unused when outside the grid
      push_item.d2  = oor_ff ? '0 : D2_W'(dx_sq + dy_sq);
   end

endmodule

### src/rch_queue.sv
// short queue between the front end and the square root back end
// depends on rch_pkg
module rch_queue
   import rch_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  item_type   push_item,
   input  logic       pop,
   output item_type   pop_item,
   output q_stat_type q_stat
);

   item_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      q_stat.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
      q_stat.avail = (count_ff != '0);
      do_push   = push && !q_stat.full;
      do_pop    = pop && q_stat.avail;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
      pop_item  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/rch_back.sv
// back end: pipelined square root, one root bit per stage, then the height scaling
// depends on rch_pkg
module rch_back
   import rch_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  q_stat_type          q_stat,
   input  item_type            pop_item,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [HEIGHT_W-1:0] height,
   output logic                out_of_range
);

   sq_stage_type        st_ff [ROOT_W+1];
   sq_stage_type        st_in [ROOT_W+1];
   logic [ROOT_W:0]     vld_ff;
   logic                adv;
   logic                out_valid_ff;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                oor_ff;
   logic [ROOT_W-1:0]   half_fx, diff;

   // whole pipeline moves together; the output register is its last stage
   assign adv = !out_valid_ff || out_ready;
   assign pop = adv && q_stat.avail;

   always_comb begin
      st_in[0].lod  = pop_item.lod;
      st_in[0].oor  = pop_item.oor;
      st_in[0].d2   = pop_item.d2;
      st_in[0].root = '0;
      st_in[0].rem  = '0;
   end

   for (genvar i = 1; i <= ROOT_W; i++) begin : g_step
      localparam int K = ROOT_W - i;
      logic [1:0]       pair;
      logic [REM_W-1:0] acc, trial;

      if (K >= FRAC_BITS) begin : g_data
         assign pair = st_ff[i-1].d2[2*(K-FRAC_BITS) +: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      always_comb begin
         acc   = {st_ff[i-1].rem[REM_W-3:0], pair};
         trial = REM_W'({st_ff[i-1].root, 2'b01});
         st_in[i].lod = st_ff[i-1].lod;
         st_in[i].oor = st_ff[i-1].oor;
         st_in[i].d2  = st_ff[i-1].d2;
         if (acc >= trial) begin
            st_in[i].rem  = acc - trial;
            st_in[i].root = {st_ff[i-1].root[ROOT_W-2:0], 1'b1};
         end else begin
            st_in[i].rem  = acc;
            st_in[i].root = {st_ff[i-1].root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      half_fx = ROOT_W'(1 << FRAC_BITS) << st_ff[ROOT_W].lod;
      diff    = half_fx - st_ff[ROOT_W].root;
      if (st_ff[ROOT_W].oor || (st_ff[ROOT_W].root >= half_fx)) begin
         height_in = '0;
      end else begin
         height_in = HEIGHT_W'(diff >> st_ff[ROOT_W].lod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[ROOT_W-1:0], pop};
         out_valid_ff <= vld_ff[ROOT_W];
      end
      if (adv) begin
         for (int j = 0; j <= ROOT_W; j++) begin
            st_ff[j] <= st_in[j];
         end
         height_ff <= height_in;
         oor_ff    <= st_ff[ROOT_W].oor;
      end
   end

   assign out_valid    = out_valid_ff;
   assign height       = height_ff;
   assign out_of_range = oor_ff;

endmodule

### src/radial_cone_height_top.sv
// Radial cone height block.
// Each beat on req carries a pixel (column, row) of a square stamp grid whose
// side is 2 << level_of_detail; the matching rsp beat carries the cone height
// at that pixel in unsigned Q1.16 (65536 is 1.0) and an out-of-range flag for
// pixels at or beyond the grid side, which read height 0.
// level_of_detail is written through csr_wr_en / csr_wr_data while no beats
// are in flight; values above 9 act as 9. Reset sets it to 9.
// Throughput is one beat per cycle while rsp_tready stays high. After the
// front stage takes a beat, it passes through the queue write, one load
// stage, 26 square root stages (one root bit each) and the output register
// to rsp_tvalid. The square root pipeline sets that depth.
// Reset empties the front stage, the queue and the pipeline. When the receiver
// holds rsp_tready low the pipeline freezes, the four-entry queue fills and
// then req_tready drops; no beat is lost or repeated.
// depends on rch_pkg, rch_front, rch_queue, rch_back
module radial_cone_height_top
   import rch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // column [9:0], row [19:10], zeros above
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // height [16:0], zeros above
   output logic                  rsp_tuser,  // out_of_range [0]
   input  logic                  csr_wr_en,
   input  logic [LOD_W-1:0]      csr_wr_data
);

   logic [LOD_W-1:0]    lod_ff, lod_eff;
   q_stat_type          q_stat;
   logic                push, pop;
   item_type            push_item, pop_item;
   logic [HEIGHT_W-1:0] height;

   always_ff @(posedge clock) begin
      if (reset) begin
         lod_ff <= LOD_W'(LOD_RESET);
      end else if (csr_wr_en) begin
         lod_ff <= csr_wr_data;
      end
   end

   assign lod_eff = (lod_ff > LOD_W'(MAX_LOD)) ? LOD_W'(MAX_LOD) : lod_ff;

   rch_front u_front (
      .clock     (clock),
      .reset     (reset),
      .lod       (lod_eff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .column    (req_tdata[COORD_W-1:0]),
      .row       (req_tdata[2*COORD_W-1:COORD_W]),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   rch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   rch_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .pop_item     (pop_item),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .height       (height),
      .out_of_range (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(height);

endmodule

### src/rch_checker.sv
// port-level checks for the radial cone height block, bound to the top level
// depends on rch_pkg and radial_cone_height_top
module rch_checker
   import rch_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   // a stalled beat keeps its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // out of range pixels read flat
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[HEIGHT_W-1:0] == '0)
      else $error("out of range beat with non-zero height");

   // height never above 1.0 and padding stays clear
   a_height_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= RSP_DATA_W'(1 << FRAC_BITS))
      else $error("height above one");

endmodule

bind radial_cone_height_top rch_checker u_rch_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
